// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the CAN bit-timing search RTL.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every rising clock edge outside reset.
`define CBTS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define CBTS_ASSERT_NEXT(label, clk, rst_n, cond, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (post)) \
        else $error(msg);
`else
`define CBTS_ASSERT(label, clk, rst_n, prop, msg)
`define CBTS_ASSERT_NEXT(label, clk, rst_n, cond, post, msg)
`endif
`endif

// ===== hw/rtl/cbts_pkg.sv =====
// Shared constants, bit-rate table and control/status types for the
// CAN bit-timing search. No dependencies.
package cbts_pkg;

    localparam int CLK_W         = 32;
    localparam int IDX_W         = 5;
    localparam int RATE_W        = 20;
    localparam int MAX_PRESCALER = 512;
    localparam int PRE_W         = $clog2(MAX_PRESCALER + 1);
    localparam int PRE_OUT_W     = 10;
    localparam int DIV_W         = RATE_W + PRE_W;
    localparam int STEP_W        = $clog2(CLK_W);
    localparam int SEG_W         = 8;
    localparam int TICK_W        = 9;
    localparam int RATE_COUNT    = 21;

    localparam logic [CLK_W-1:0] CLOCK_RESET = 32'd80000000;

    localparam logic [TICK_W-1:0] SEG1_MIN = 9'd2;
    localparam logic [TICK_W-1:0] SEG1_MAX = 9'd255;
    // segment two plus one (sync tick folded in)
    localparam logic [TICK_W-1:0] SEG2P1_MIN = 9'd3;
    localparam logic [TICK_W-1:0] SEG2P1_MAX = 9'd129;

    typedef struct packed {
        logic load;    // take a new item
        logic mul;     // form divisor, start a trial
        logic step;    // one restoring division step
        logic next;    // advance the prescaler
        logic save;    // write the result register
        logic found;   // with save: result is a fit
    } cmd_t;

    typedef struct packed {
        logic bad_idx;
        logic last_step;
        logic fit;
        logic pre_last;
    } sts_t;

    function automatic logic [RATE_W-1:0] rate_lookup(input logic [IDX_W-1:0] idx);
        logic [RATE_W-1:0] r;
        unique case (idx)
            5'd0:    r = 20'd1000;
            5'd1:    r = 20'd5000;
            5'd2:    r = 20'd10000;
            5'd3:    r = 20'd12500;
            5'd4:    r = 20'd16000;
            5'd5:    r = 20'd20000;
            5'd6:    r = 20'd25000;
            5'd7:    r = 20'd31250;
            5'd8:    r = 20'd33000;
            5'd9:    r = 20'd40000;
            5'd10:   r = 20'd50000;
            5'd11:   r = 20'd80000;
            5'd12:   r = 20'd83300;
            5'd13:   r = 20'd95000;
            5'd14:   r = 20'd100000;
            5'd15:   r = 20'd125000;
            5'd16:   r = 20'd200000;
            5'd17:   r = 20'd250000;
            5'd18:   r = 20'd500000;
            5'd19:   r = 20'd800000;
            5'd20:   r = 20'd1000000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/can_bit_timing_search.sv =====
// CAN nominal bit-timing search: one result per bit-rate index.
// Each prescaler trial runs a divisor multiply, 32 steps of the shared restoring
// divider and a segment check. Prescalers are tried from 1 up to 512; the first fit
// is saved, else a no-fit result; a bad index is saved without any trial.
// One item at a time; the next is taken once the save returns the sequencer to idle, and a waiting result lets it in.
// aresetn (synchronous, active low) clears control and sets the clock to 80 MHz.
module can_bit_timing_search (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [cbts_pkg::CLK_W-1:0]         cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [cbts_pkg::IDX_W-1:0]         s_bitrate_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_found,
    output logic [cbts_pkg::PRE_OUT_W-1:0]     m_prescaler,
    output logic [cbts_pkg::SEG_W-1:0]         m_segment_one,
    output logic [cbts_pkg::SEG_W-1:0]         m_segment_two,
    output logic                               m_jump_width
);

    cbts_pkg::cmd_t cmd;
    cbts_pkg::sts_t sts;

    cbts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cbts_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_bitrate_index (s_bitrate_index),
        .cmd             (cmd),
        .sts             (sts),
        .m_found         (m_found),
        .m_prescaler     (m_prescaler),
        .m_segment_one   (m_segment_one),
        .m_segment_two   (m_segment_two),
        .m_jump_width    (m_jump_width)
    );

endmodule

// ===== hw/rtl/cbts_ctrl.sv =====
// Sequencer for the bit-timing search: steps trials of the shared divider.
// Depends on cbts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbts_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  cbts_pkg::sts_t sts,
    output cbts_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_CHECK = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (sts.bad_idx) begin
                    // hold until the result register is free
                    if (out_free) begin
                        cmd.save   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.mul    = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (sts.last_step) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (sts.fit || sts.pre_last) begin
                    if (out_free) begin
                        cmd.save   = 1'b1;
                        cmd.found  = sts.fit;
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.next   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.save) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `CBTS_ASSERT(a_save_free, aclk, aresetn, !cmd.save || !m_valid_reg || m_ready, "result overwritten before taken")
    `CBTS_ASSERT_NEXT(a_load_mul, aclk, aresetn, cmd.load, state_reg == ST_MUL, "item accepted but no trial started")
    `CBTS_ASSERT_NEXT(a_save_valid, aclk, aresetn, cmd.save, m_valid_reg, "saved result not presented")
    `CBTS_ASSERT(a_step_only, aclk, aresetn, !cmd.step || !(cmd.save || cmd.mul || cmd.load), "divider step mixed with other commands")

endmodule

// ===== hw/rtl/cbts_dp.sv =====
// Datapath: kernel clock register, prescaler counter, shared restoring divider,
// segment check and result register. Depends on cbts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbts_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [cbts_pkg::CLK_W-1:0]         cfg_wr_data,
    input  logic [cbts_pkg::IDX_W-1:0]         s_bitrate_index,
    input  cbts_pkg::cmd_t                     cmd,
    output cbts_pkg::sts_t                     sts,
    output logic                               m_found,
    output logic [cbts_pkg::PRE_OUT_W-1:0]     m_prescaler,
    output logic [cbts_pkg::SEG_W-1:0]         m_segment_one,
    output logic [cbts_pkg::SEG_W-1:0]         m_segment_two,
    output logic                               m_jump_width
);

    logic [cbts_pkg::CLK_W-1:0]     clk_hz_reg;
    logic [cbts_pkg::RATE_W-1:0]    rate_reg;
    logic                           bad_reg;
    logic [cbts_pkg::PRE_W-1:0]     pre_reg;
    logic [cbts_pkg::DIV_W-1:0]     div_reg;
    logic [cbts_pkg::DIV_W-1:0]     rem_reg;
    logic [cbts_pkg::CLK_W-1:0]     quo_reg;
    logic [cbts_pkg::STEP_W-1:0]    cnt_reg;

    logic [cbts_pkg::DIV_W:0]       shifted;
    logic                           q_bit;
    logic [cbts_pkg::DIV_W:0]       diff;

    logic [cbts_pkg::TICK_W-1:0]    ticks;
    logic                           ticks_small;
    logic [cbts_pkg::TICK_W+1:0]    ticks3;
    logic [cbts_pkg::TICK_W-1:0]    seg1;
    logic [cbts_pkg::TICK_W-1:0]    seg2p1;
    logic [cbts_pkg::TICK_W-1:0]    seg2;

    logic                           res_found_reg;
    logic [cbts_pkg::PRE_OUT_W-1:0] res_pre_reg;
    logic [cbts_pkg::SEG_W-1:0]     res_s1_reg;
    logic [cbts_pkg::SEG_W-1:0]     res_s2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clk_hz_reg <= cbts_pkg::CLOCK_RESET;
        end else if (cfg_wr_en) begin
            clk_hz_reg <= cfg_wr_data;
        end
    end

    // restoring division: shift in next dividend bit, subtract if it fits
    assign shifted = {rem_reg, quo_reg[cbts_pkg::CLK_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign q_bit   = (shifted >= {1'b0, div_reg});

    // segment split of the quotient; anything above 511 ticks cannot fit
    assign ticks       = quo_reg[cbts_pkg::TICK_W-1:0];
    assign ticks_small = (quo_reg[cbts_pkg::CLK_W-1:cbts_pkg::TICK_W] == '0);
    assign ticks3      = (cbts_pkg::TICK_W+2)'(ticks) * (cbts_pkg::TICK_W+2)'(3);
    assign seg1        = ticks3[cbts_pkg::TICK_W+1:2];
    assign seg2p1      = ticks - seg1;
    assign seg2        = seg2p1 - cbts_pkg::TICK_W'(1);

    assign sts.bad_idx   = bad_reg;
    assign sts.last_step = (cnt_reg == cbts_pkg::STEP_W'(cbts_pkg::CLK_W - 1));
    assign sts.pre_last  = (pre_reg == cbts_pkg::PRE_W'(cbts_pkg::MAX_PRESCALER));
    assign sts.fit       = (rem_reg == '0) && ticks_small
                           && (seg1 >= cbts_pkg::SEG1_MIN) && (seg1 <= cbts_pkg::SEG1_MAX)
                           && (seg2p1 >= cbts_pkg::SEG2P1_MIN)
                           && (seg2p1 <= cbts_pkg::SEG2P1_MAX);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rate_reg <= cbts_pkg::rate_lookup(s_bitrate_index);
            bad_reg  <= (s_bitrate_index >= cbts_pkg::IDX_W'(cbts_pkg::RATE_COUNT));
            pre_reg  <= cbts_pkg::PRE_W'(1);
        end else if (cmd.next) begin
            pre_reg  <= pre_reg + cbts_pkg::PRE_W'(1);
        end
        if (cmd.mul) begin
            div_reg <= cbts_pkg::DIV_W'(rate_reg) * cbts_pkg::DIV_W'(pre_reg);
            rem_reg <= '0;
            quo_reg <= clk_hz_reg;
            cnt_reg <= '0;
        end else if (cmd.step) begin
            rem_reg <= q_bit ? diff[cbts_pkg::DIV_W-1:0] : shifted[cbts_pkg::DIV_W-1:0];
            quo_reg <= {quo_reg[cbts_pkg::CLK_W-2:0], q_bit};
            cnt_reg <= cnt_reg + cbts_pkg::STEP_W'(1);
        end
        if (cmd.save) begin
            res_found_reg <= cmd.found;
            res_pre_reg   <= cmd.found ? cbts_pkg::PRE_OUT_W'(pre_reg) : '0;
            res_s1_reg    <= cmd.found ? seg1[cbts_pkg::SEG_W-1:0] : '0;
            res_s2_reg    <= cmd.found ? seg2[cbts_pkg::SEG_W-1:0] : '0;
        end
    end

    assign m_found       = res_found_reg;
    assign m_prescaler   = res_pre_reg;
    assign m_segment_one = res_s1_reg;
    assign m_segment_two = res_s2_reg;
    assign m_jump_width  = res_found_reg;

    `CBTS_ASSERT_NEXT(a_rem_below, aclk, aresetn, cmd.step, rem_reg < div_reg,
        "divider remainder not below divisor")
    `CBTS_ASSERT_NEXT(a_found_seg, aclk, aresetn, cmd.save && cmd.found,
        res_s1_reg >= 8'd2 && res_s2_reg >= 8'd2, "reported segment out of range")
    `CBTS_ASSERT(a_fit_exact, aclk, aresetn,
        !(cmd.save && cmd.found) || (rem_reg == '0 && !bad_reg),
        "fit reported with remainder or bad index")

endmodule
